// ===== src/smh_pkg.sv =====
// Shared constants and types for the stable integer mix hash.
package smh_pkg;

  localparam logic [63:0] MixGolden = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MixMulA   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MixMulB   = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] FnvPrime  = 64'h0000_0100_0000_01B3;

  // Pipeline depths in clock cycles.
  localparam int MulLatency   = 2;
  localparam int FinLatency   = 1 + 2 * MulLatency;
  localparam int FoldLatency  = MulLatency + FinLatency;
  localparam int MergeLatency = FinLatency + 2 * FoldLatency;

  typedef enum logic [1:0] {
    CmdMixOne     = 2'd0,
    CmdCombTwo    = 2'd1,
    CmdCombThree  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctrl_t;

endpackage

// ===== src/stable_integer_mix_hash.sv =====
// Stable 64-bit integer mix hash: three finalizer lanes and an in-order fold.
// A request passes one finalizer, two folds (a multiply and a finalizer each) and the output reg
// on its way from the edge that takes the request to the edge that takes the result.
// Throughput: one request per cycle; busy stays low since the pipeline never stalls.
// The receiver cannot stall, so each result shows on mixed_value for one cycle.
// Reset clears the valid pipeline and done; data registers are not reset.
module stable_integer_mix_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [63:0] first_value,
  input  logic [63:0] second_value,
  input  logic [63:0] third_value,
  output logic        done,
  output logic [63:0] mixed_value
);

  localparam int CtrlDepth = smh_pkg::MergeLatency;

  smh_pkg::ctrl_t ctrl_pipe [CtrlDepth];
  smh_pkg::ctrl_t ctrl_out;
  logic [63:0]    lane1;
  logic [63:0]    lane2;
  logic [63:0]    lane3;
  logic [63:0]    acc_one;
  logic [63:0]    acc_two;
  logic [63:0]    acc_three;
  logic [63:0]    result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CtrlDepth; i++) ctrl_pipe[i] <= '0;
    end else begin
      ctrl_pipe[0].valid <= start && !busy;
      ctrl_pipe[0].cmd   <= smh_pkg::cmd_t'(cmd);
      for (int i = 1; i < CtrlDepth; i++) ctrl_pipe[i] <= ctrl_pipe[i-1];
    end
  end

  smh_fin u_lane1 (.clk(clk), .din(first_value),  .dout(lane1));
  smh_fin u_lane2 (.clk(clk), .din(second_value), .dout(lane2));
  smh_fin u_lane3 (.clk(clk), .din(third_value),  .dout(lane3));

  smh_merge u_merge (
    .clk       (clk),
    .lane1     (lane1),
    .lane2     (lane2),
    .lane3     (lane3),
    .acc_one   (acc_one),
    .acc_two   (acc_two),
    .acc_three (acc_three)
  );

  assign ctrl_out = ctrl_pipe[CtrlDepth-1];

  // The undefined command code finalizes the first value only.
  always_comb begin
    unique case (ctrl_out.cmd)
      smh_pkg::CmdCombTwo:   result_next = acc_two;
      smh_pkg::CmdCombThree: result_next = acc_three;
      default:               result_next = acc_one;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_out.valid;
    end
    mixed_value <= result_next;
  end

endmodule

// ===== src/smh_mul64.sv =====
// Two-stage 64x64 multiplier that keeps the low 64 bits of the product.
module smh_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] pp_ll;
  logic [31:0] pp_lh;
  logic [31:0] pp_hl;
  logic [63:0] ll_c;
  logic [31:0] lh_c;
  logic [31:0] hl_c;

  // Only the low halves of the cross products reach the low 64 result bits.
  assign ll_c = a[31:0] * b[31:0];
  assign lh_c = a[31:0] * b[63:32];
  assign hl_c = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    pp_ll <= ll_c;
    pp_lh <= lh_c;
    pp_hl <= hl_c;
    p     <= pp_ll + {pp_lh + pp_hl, 32'd0};
  end

endmodule

// ===== src/smh_fin.sv =====
// One hash lane: the pipelined splitmix64 finalizer.
module smh_fin (
  input  logic        clk,
  input  logic [63:0] din,
  output logic [63:0] dout
);

  logic [63:0] z;
  logic [63:0] ya;
  logic [63:0] yb;

  always_ff @(posedge clk) begin
    z <= din + smh_pkg::MixGolden;
  end

  smh_mul64 u_mul_a (
    .clk (clk),
    .a   (z ^ (z >> 30)),
    .b   (smh_pkg::MixMulA),
    .p   (ya)
  );

  smh_mul64 u_mul_b (
    .clk (clk),
    .a   (ya ^ (ya >> 27)),
    .b   (smh_pkg::MixMulB),
    .p   (yb)
  );

  assign dout = yb ^ (yb >> 31);

endmodule

// ===== src/smh_merge.sv =====
// Merging stage: folds the lane hashes in order and aligns the three candidates.
module smh_merge (
  input  logic        clk,
  input  logic [63:0] lane1,
  input  logic [63:0] lane2,
  input  logic [63:0] lane3,
  output logic [63:0] acc_one,
  output logic [63:0] acc_two,
  output logic [63:0] acc_three
);

  localparam int Lane2Delay = smh_pkg::MulLatency;
  localparam int Lane3Delay = smh_pkg::FoldLatency + smh_pkg::MulLatency;
  localparam int Acc1Delay  = 2 * smh_pkg::FoldLatency;
  localparam int Acc2Delay  = smh_pkg::FoldLatency;

  logic [63:0] lane2_dly [Lane2Delay];
  logic [63:0] lane3_dly [Lane3Delay];
  logic [63:0] acc1_dly  [Acc1Delay];
  logic [63:0] acc2_dly  [Acc2Delay];
  logic [63:0] prod1;
  logic [63:0] prod2;
  logic [63:0] acc2;

  // Delay lines keep each lane result in step with the running hash.
  always_ff @(posedge clk) begin
    lane2_dly[0] <= lane2;
    lane3_dly[0] <= lane3;
    acc1_dly[0]  <= lane1;
    acc2_dly[0]  <= acc2;
    for (int i = 1; i < Lane2Delay; i++) lane2_dly[i] <= lane2_dly[i-1];
    for (int i = 1; i < Lane3Delay; i++) lane3_dly[i] <= lane3_dly[i-1];
    for (int i = 1; i < Acc1Delay; i++)  acc1_dly[i]  <= acc1_dly[i-1];
    for (int i = 1; i < Acc2Delay; i++)  acc2_dly[i]  <= acc2_dly[i-1];
  end

  smh_mul64 u_fold1_mul (
    .clk (clk),
    .a   (lane1),
    .b   (smh_pkg::FnvPrime),
    .p   (prod1)
  );

  smh_fin u_fold1_fin (
    .clk  (clk),
    .din  (prod1 ^ lane2_dly[Lane2Delay-1]),
    .dout (acc2)
  );

  smh_mul64 u_fold2_mul (
    .clk (clk),
    .a   (acc2),
    .b   (smh_pkg::FnvPrime),
    .p   (prod2)
  );

  smh_fin u_fold2_fin (
    .clk  (clk),
    .din  (prod2 ^ lane3_dly[Lane3Delay-1]),
    .dout (acc_three)
  );

  assign acc_one = acc1_dly[Acc1Delay-1];
  assign acc_two = acc2_dly[Acc2Delay-1];

endmodule
